// ===== hw/rtl/mse_pkg.sv =====
// Package: shared constants and types for the MIPS subset execute block.
`timescale 1ns / 1ps
package mse_pkg;
	localparam int unsigned MEM_BYTES_DEF = 65536;
	localparam logic [31:0] START_PC_RST = 32'h0000_1000;

	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_WR = 2'd1;
	localparam logic [1:0] CMD_RD = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_SYSCALL = 2'd2;
	localparam logic [1:0] ST_FAULT = 2'd3;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J = 6'h02;
	localparam logic [5:0] OP_JAL = 6'h03;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI = 6'h0a;
	localparam logic [5:0] OP_SLTIU = 6'h0b;
	localparam logic [5:0] OP_ANDI = 6'h0c;
	localparam logic [5:0] OP_ORI = 6'h0d;
	localparam logic [5:0] OP_XORI = 6'h0e;
	localparam logic [5:0] OP_LUI = 6'h0f;
	localparam logic [5:0] OP_LB = 6'h20;
	localparam logic [5:0] OP_LH = 6'h21;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_LBU = 6'h24;
	localparam logic [5:0] OP_LHU = 6'h25;
	localparam logic [5:0] OP_SB = 6'h28;
	localparam logic [5:0] OP_SH = 6'h29;
	localparam logic [5:0] OP_SW = 6'h2b;

	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_JR = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	localparam logic [31:0] PC_TOP_MASK = 32'hf000_0000;

	// Result beat fields.
	typedef struct packed {
		logic [31:0] read_word;
		logic [31:0] syscall_argument;
		logic [31:0] syscall_number;
		logic [1:0] status;
		logic [31:0] next_pc;
	} res_t;
endpackage

// ===== hw/rtl/mse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module mse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/mips_subset_execute.sv =====
// Top level: MIPS32 subset executor with register file and data memory in RAM.
//
// Usage: one command beat enters on s_axis (tuser = command, tdata = instruction,
// mem_address, write_word) and one result beat leaves on m_axis (tuser = status,
// tdata = next_pc, syscall_number, syscall_argument, read_word).
// Each beat passes through stage one and stage two: the accept edge reads the
// register file (four read copies: rs, rt, v0 and a0); stage one decodes, with the
// register write of the accept edge forwarded, and reads the data memory word at
// its end; stage two merges loads and stores, and its closing edge, once the output
// register is free or draining, writes back registers and memory, updates the pc
// and loads the result register. A byte or halfword store reads the word in stage
// one and writes it in stage two. The next beat is taken at the write-back edge,
// so no new beat is taken until the one before it commits, as set by the
// read-then-write of the register file and data memory ports.
// Reset loads the pc with 0x1000 (START_PC_RST) and clears the register file
// through per-register valid bits; data memory is undefined until written. A
// stalled receiver holds the result; the following beat waits in stage two
// without committing, and no new beat is taken meanwhile.
// A write on cfg_we/cfg_wdata also loads the pc.
`timescale 1ns / 1ps
module mips_subset_execute #(
	parameter int unsigned MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: instruction[31:0], mem_address[47:32], write_word[79:48]
	input logic [79:0] s_axis_tdata,
	// tuser: command[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: next_pc[31:0], syscall_number[63:32], syscall_argument[95:64],
	// read_word[127:96]
	output logic [127:0] m_axis_tdata,
	// tuser: status[1:0]
	output logic [1:0] m_axis_tuser
);
	import mse_pkg::*;

	localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
	localparam int unsigned MAW = $clog2(MEM_WORDS);

	logic [31:0] pc_q;
	logic [31:0] rf_valid_q;
	logic busy_s1;
	logic busy_s2;
	logic s2_go;
	logic [1:0] cmd_s1;
	logic [31:0] inst_s1;
	logic [15:0] maddr_s1;
	logic [31:0] wword_s1;
	logic out_valid_q;
	res_t out_q;

	// Accept a beat when stage one is empty and stage two is empty or committing
	assign s_axis_tready = !busy_s1 && (!busy_s2 || s2_go);
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// Field decode of the incoming beat for RAM read addresses
	logic [31:0] in_inst;
	assign in_inst = s_axis_tdata[31:0];

	// Register file copies: rs port, rt port, syscall ports (v0, a0)
	logic rf_we;
	logic [4:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic [31:0] rs_raw, rt_raw, v0_raw, a0_raw;

	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(acc), .raddr(in_inst[25:21]), .rdata(rs_raw));
	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(acc), .raddr(in_inst[20:16]), .rdata(rt_raw));
	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_v (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(acc), .raddr(5'd2), .rdata(v0_raw));
	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_g (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(acc), .raddr(5'd4), .rdata(a0_raw));

	// Stage one capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1 <= s_axis_tuser;
			inst_s1 <= in_inst;
			maddr_s1 <= s_axis_tdata[47:32];
			wword_s1 <= s_axis_tdata[79:48];
		end
	end

	// Hold the register write of the last edge to cover a read at that edge
	logic fwd_we_q;
	logic [4:0] fwd_addr_q;
	logic [31:0] fwd_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_we_q <= 1'b0;
		end else begin
			fwd_we_q <= rf_we;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			fwd_addr_q <= rf_waddr;
			fwd_data_q <= rf_wdata;
		end
	end

	// Register values: forwarded write first, then valid bits; r0 reads zero
	logic [4:0] rs, rt, rd, sa;
	logic [5:0] op, fn;
	logic [15:0] imm;
	logic [31:0] a, b, v0, a0;
	assign op = inst_s1[31:26];
	assign rs = inst_s1[25:21];
	assign rt = inst_s1[20:16];
	assign rd = inst_s1[15:11];
	assign sa = inst_s1[10:6];
	assign fn = inst_s1[5:0];
	assign imm = inst_s1[15:0];
	assign a = (fwd_we_q && fwd_addr_q == rs) ? fwd_data_q :
		rf_valid_q[rs] ? rs_raw : 32'd0;
	assign b = (fwd_we_q && fwd_addr_q == rt) ? fwd_data_q :
		rf_valid_q[rt] ? rt_raw : 32'd0;
	assign v0 = (fwd_we_q && fwd_addr_q == 5'd2) ? fwd_data_q :
		rf_valid_q[2] ? v0_raw : 32'd0;
	assign a0 = (fwd_we_q && fwd_addr_q == 5'd4) ? fwd_data_q :
		rf_valid_q[4] ? a0_raw : 32'd0;

	// Decode and execute, computing the memory access
	logic [31:0] sx, pc4, npc, val, addr, mem_a;
	logic [4:0] dest;
	logic wr, is_mem, is_store, is_load, mem_ok;
	logic [1:0] st, size_code;

	assign sx = {{16{imm[15]}}, imm};
	assign pc4 = pc_q + 32'd4;
	assign addr = a + sx;

	always_comb begin
		npc = pc4;
		val = 32'd0;
		dest = rt;
		wr = 1'b0;
		st = ST_OK;
		is_mem = 1'b0;
		is_store = 1'b0;
		size_code = 2'd0;
		case (op)
			OP_SPECIAL: begin
				dest = rd;
				wr = 1'b1;
				case (fn)
					FN_SLL: val = b << sa;
					FN_SRL: val = b >> sa;
					FN_SRA: val = $signed(b) >>> sa;
					FN_JR: begin
						wr = 1'b0;
						npc = a;
					end
					FN_JALR: begin
						val = pc4;
						npc = a;
					end
					FN_SYSCALL: begin
						wr = 1'b0;
						st = ST_SYSCALL;
					end
					FN_ADDU: val = a + b;
					FN_SUBU: val = a - b;
					FN_AND: val = a & b;
					FN_OR: val = a | b;
					FN_XOR: val = a ^ b;
					FN_NOR: val = ~(a | b);
					FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
					FN_SLTU: val = {31'd0, a < b};
					default: begin
						wr = 1'b0;
						st = ST_ILLEGAL;
					end
				endcase
			end
			OP_J: npc = (pc4 & PC_TOP_MASK) | {4'd0, inst_s1[25:0], 2'b00};
			OP_JAL: begin
				dest = 5'd31;
				val = pc4;
				wr = 1'b1;
				npc = (pc4 & PC_TOP_MASK) | {4'd0, inst_s1[25:0], 2'b00};
			end
			OP_BEQ: if (a == b) npc = pc4 + {sx[29:0], 2'b00};
			OP_BNE: if (a != b) npc = pc4 + {sx[29:0], 2'b00};
			OP_ADDIU: begin
				wr = 1'b1;
				val = addr;
			end
			OP_SLTI: begin
				wr = 1'b1;
				val = {31'd0, $signed(a) < $signed(sx)};
			end
			OP_SLTIU: begin
				wr = 1'b1;
				val = {31'd0, a < sx};
			end
			OP_ANDI: begin
				wr = 1'b1;
				val = a & {16'd0, imm};
			end
			OP_ORI: begin
				wr = 1'b1;
				val = a | {16'd0, imm};
			end
			OP_XORI: begin
				wr = 1'b1;
				val = a ^ {16'd0, imm};
			end
			OP_LUI: begin
				wr = 1'b1;
				val = {imm, 16'd0};
			end
			OP_LB, OP_LBU: begin
				is_mem = 1'b1;
				size_code = 2'd0;
			end
			OP_LH, OP_LHU: begin
				is_mem = 1'b1;
				size_code = 2'd1;
			end
			OP_LW: begin
				is_mem = 1'b1;
				size_code = 2'd2;
			end
			OP_SB: begin
				is_mem = 1'b1;
				is_store = 1'b1;
				size_code = 2'd0;
			end
			OP_SH: begin
				is_mem = 1'b1;
				is_store = 1'b1;
				size_code = 2'd1;
			end
			OP_SW: begin
				is_mem = 1'b1;
				is_store = 1'b1;
				size_code = 2'd2;
			end
			default: st = ST_ILLEGAL;
		endcase
	end
	assign is_load = is_mem && !is_store;

	// Pick the address of this beat: instruction or host command
	logic is_exec;
	assign is_exec = cmd_s1 == CMD_EXEC;
	always_comb begin
		if (is_exec) begin
			mem_a = addr;
		end else begin
			mem_a = {16'd0, maddr_s1};
		end
	end

	// Address checks: alignment and range; host commands move whole words
	logic aligned, in_range;
	always_comb begin
		case (is_exec ? size_code : 2'd2)
			2'd1: aligned = !mem_a[0];
			2'd2: aligned = mem_a[1:0] == 2'b00;
			default: aligned = 1'b1;
		endcase
	end
	assign in_range = (mem_a >> 2) < 32'(MEM_WORDS);
	assign mem_ok = aligned && in_range;

	// Phase two of a beat: stage two holds the read data
	logic [31:0] dm_rdata;
	logic [31:0] mem_a_s2, b_s2, wword_s2;
	logic [1:0] size_s2;
	logic [5:0] op_s2;
	logic [1:0] cmd_s2, st_s2;
	logic [4:0] dest_s2;
	logic wr_s2, load_s2, store_s2, mem_ok_s2;
	logic [31:0] npc_s2, val_s2, v0_s2, a0_s2;

	logic dm_re;
	assign dm_re = busy_s1;

	// Commit stage two when the output register is free or draining
	assign s2_go = busy_s2 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
		end else begin
			busy_s2 <= busy_s1 || (busy_s2 && !s2_go);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			mem_a_s2 <= mem_a;
			b_s2 <= b;
			wword_s2 <= wword_s1;
			size_s2 <= size_code;
			op_s2 <= op;
			cmd_s2 <= cmd_s1;
			st_s2 <= st;
			dest_s2 <= dest;
			wr_s2 <= wr;
			load_s2 <= is_load;
			store_s2 <= is_store;
			mem_ok_s2 <= mem_ok;
			npc_s2 <= npc;
			val_s2 <= val;
			v0_s2 <= v0;
			a0_s2 <= a0;
		end
	end

	// Data memory: read in stage one, merge and write in stage two
	logic dm_we;
	logic [31:0] dm_wdata;
	mse_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(mem_a_s2[MAW+1:2]), .wdata(dm_wdata),
		.re(dm_re), .raddr(mem_a[MAW+1:2]), .rdata(dm_rdata));

	// Resolve stage two outcome
	logic [31:0] shifted, load_val, fin_val, fin_npc, rword;
	logic [1:0] fin_st;
	logic fin_wr;
	logic [4:0] bsh;
	assign bsh = {mem_a_s2[1:0], 3'b000};
	assign shifted = dm_rdata >> bsh;

	always_comb begin
		case (op_s2)
			OP_LB: load_val = {{24{shifted[7]}}, shifted[7:0]};
			OP_LBU: load_val = {24'd0, shifted[7:0]};
			OP_LH: load_val = {{16{shifted[15]}}, shifted[15:0]};
			OP_LHU: load_val = {16'd0, shifted[15:0]};
			default: load_val = dm_rdata;
		endcase
	end

	always_comb begin
		logic [31:0] mask;
		mask = 32'd0;
		dm_we = 1'b0;
		dm_wdata = dm_rdata;
		fin_wr = 1'b0;
		fin_val = val_s2;
		fin_npc = pc_q;
		fin_st = ST_OK;
		rword = 32'd0;
		case (cmd_s2)
			CMD_EXEC: begin
				if (st_s2 == ST_ILLEGAL) begin
					fin_st = ST_ILLEGAL;
				end else if ((load_s2 || store_s2) && !mem_ok_s2) begin
					fin_st = ST_FAULT;
				end else begin
					fin_st = st_s2;
					fin_npc = npc_s2;
					fin_wr = wr_s2 || load_s2;
					if (load_s2) begin
						fin_val = load_val;
					end
					if (store_s2) begin
						dm_we = s2_go;
						case (size_s2)
							2'd0: mask = 32'h0000_00ff << bsh;
							2'd1: mask = 32'h0000_ffff << bsh;
							default: mask = 32'hffff_ffff;
						endcase
						dm_wdata = (dm_rdata & ~mask) | ((b_s2 << bsh) & mask);
					end
				end
			end
			CMD_WR: begin
				if (!mem_ok_s2) begin
					fin_st = ST_FAULT;
				end else begin
					dm_we = s2_go;
					dm_wdata = wword_s2;
				end
			end
			CMD_RD: begin
				if (!mem_ok_s2) begin
					fin_st = ST_FAULT;
				end else begin
					rword = dm_rdata;
				end
			end
			default: fin_st = ST_ILLEGAL;
		endcase
	end

	// Register write back; r0 stays zero
	assign rf_we = s2_go && fin_wr && (dest_s2 != 5'd0);
	assign rf_waddr = dest_s2;
	assign rf_wdata = fin_val;

	// Hold the syscall fields only when a syscall is taken
	logic is_sys;
	assign is_sys = fin_st == ST_SYSCALL;

	// Pc, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= START_PC_RST;
			rf_valid_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (s2_go) begin
				pc_q <= fin_npc;
			end
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_q.next_pc <= fin_npc;
			out_q.status <= fin_st;
			out_q.syscall_number <= is_sys ? v0_s2 : 32'd0;
			out_q.syscall_argument <= is_sys ? a0_s2 : 32'd0;
			out_q.read_word <= rword;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tdata = {out_q.read_word, out_q.syscall_argument,
		out_q.syscall_number, out_q.next_pc};

	// Stages one and two are never occupied at once
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_s1 && busy_s2)) else $error("stages overlap");
	// No accept while a beat is in stage one
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !s_axis_tready) else $error("accept during stage one");
	// Each accept reaches stage two after passing through stage one
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> ##1 busy_s2)
		else $error("beat missing in stage two");
	// A stalled result beat holds steady
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed under stall");
	// Register zero is never written
	a_r0: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != 5'd0) else $error("r0 written");
endmodule
